FILE: design/venturi_airspeed_from_pressure_assert.svh
// -----------------------------------------------------------------------------
// Venturi airspeed assertion macros
// Shared property forms used by the port checker.
// -----------------------------------------------------------------------------
`ifndef VENTURI_AIRSPEED_FROM_PRESSURE_ASSERT_SVH
`define VENTURI_AIRSPEED_FROM_PRESSURE_ASSERT_SVH

// same-cycle implication
`define VAP_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VAP_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define VAP_ASSERT_DLY(lbl, ck, rn, ante, n, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

FILE: design/vap_pkg.sv
// -----------------------------------------------------------------------------
// Venturi airspeed package
// Widths, constants and shared types of the airspeed datapath.
// -----------------------------------------------------------------------------
package vap_pkg;

	localparam int DP_W       = 24;
	localparam int SPD_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int DEN_W  = 52;   // (inlet^2 - throat^2) * rho
	localparam int COEF_W = 63;   // 1310720000 * throat^2
	localparam int NUM_W  = 87;   // |dp| * coef
	localparam int Q_W    = 34;   // quotient bits
	localparam int ROOT_W = 17;
	localparam int SREM_W = 19;
	localparam int RHO_W  = 20;

	localparam int DIV_CELLS  = Q_W;
	localparam int SQRT_CELLS = ROOT_W;
	localparam int LATENCY    = 2 + DIV_CELLS + SQRT_CELLS + 1;

	localparam int DIVN_W   = 52;  // iterative divider dividend
	localparam int DIVD_W   = 35;  // iterative divider divisor
	localparam int DIV_CNT_W = $clog2(DIVN_W + 1);

	localparam logic [18:0] K_TC_SCALE = 19'd491520;
	localparam logic [16:0] K_TC_OFFS  = 17'd23730;
	localparam logic [16:0] K_TK_OFFS  = 17'd27313;
	localparam logic [29:0] K_LOG2_10  = 30'd891723283;
	localparam logic [29:0] K_LN2      = 30'd744261118;
	localparam logic [30:0] K_ONE      = 31'd1073741824;
	localparam logic [15:0] K_PVS      = 16'd61078;
	localparam logic [6:0]  K_HUNDRED  = 7'd100;
	localparam logic [13:0] K_RH_MAX   = 14'd10000;
	localparam logic [16:0] K_RHO_SCL  = 17'd100000;
	localparam logic [18:0] K_RD       = 19'd287058;
	localparam logic [18:0] K_RV       = 19'd461495;
	localparam logic [30:0] K_SPEED    = 31'd1310720000;
	localparam logic [3:0]  EXP_TERMS  = 4'd8;
	localparam logic [ROOT_W-1:0] SPEED_MAX = 17'd131071;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INLET    = 3'd0,
		REG_THROAT   = 3'd1,
		REG_AMBIENT  = 3'd2,
		REG_HUMIDITY = 3'd3,
		REG_TEMP     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]        inlet;
		logic [15:0]        throat;
		logic [16:0]        ambient;
		logic [13:0]        humidity;
		logic signed [14:0] temp;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		inlet: 16'd2000, throat: 16'd1000, ambient: 17'd101325,
		humidity: 14'd5000, temp: 15'sd2000
	};

	typedef struct packed {
		logic [DEN_W-1:0]  den;
		logic [COEF_W-1:0] coef;
		logic              geo_err;
	} flow_const_t;

	typedef struct packed {
		logic vld;
		logic neg;
		logic zero;
		logic geo;
		logic sat;
	} meta_t;

	typedef struct packed {
		logic              go;
		logic [DIVN_W-1:0] dividend;
		logic [DIVD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVN_W-1:0] quot;
		logic              rem_nz;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE, S_EQ, S_EQ_W, S_YQ, S_U, S_TERM, S_TERM_W, S_PVS, S_PVS_D, S_PVS_W,
		S_PVA, S_PVA_W, S_R1, S_R1_W, S_R2, S_R2_W, S_SQ, S_DEN
	} seq_state_t;

endpackage

FILE: design/vap_divider.sv
// -----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module vap_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  vap_pkg::div_req_t req,
	output vap_pkg::div_rsp_t rsp
);
	import vap_pkg::*;

	logic [DIVN_W-1:0]    quot_q;
	logic [DIVD_W-1:0]    rem_q;
	logic [DIVD_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIVD_W:0]      r;
	logic [DIVD_W:0]      r_sub;
	logic                 ge;

	assign r     = {rem_q, quot_q[DIVN_W-1]};
	assign ge    = r >= {1'b0, dvs_q};
	assign r_sub = r - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIVN_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[DIVN_W-2:0], ge};
			rem_q  <= ge ? r_sub[DIVD_W-1:0] : r[DIVD_W-1:0];
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = quot_q;
	assign rsp.rem_nz = |rem_q;

endmodule

FILE: design/vap_density.sv
// -----------------------------------------------------------------------------
// Air density sequencer
// Works out humid-air density and the flow constants from the settings.
// -----------------------------------------------------------------------------
module vap_density (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vap_pkg::cfg_t        cfg,
	input  logic                 cfg_we,
	output vap_pkg::flow_const_t fc,
	output logic                 busy
);
	import vap_pkg::*;

	seq_state_t        state_q, state_d;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic signed [21:0] eq_q;
	logic signed [24:0] yq_q;
	logic [29:0]        u_q;
	logic [30:0]        term_q;
	logic [31:0]        sum_q;
	logic [3:0]         k_q;
	logic [47:0]        m_q;
	logic [37:0]        pvs_q;
	logic [32:0]        pva_q;
	logic [32:0]        pd_q;
	logic [RHO_W-1:0]   r1_q;
	logic [RHO_W-1:0]   rho_q;
	logic [31:0]        isq_q;
	logic [31:0]        tsq_q;
	flow_const_t        fc_q;

	logic [15:0]        tc_ext;
	logic [15:0]        tc_mag;
	logic [34:0]        tc_prod;
	logic [16:0]        tc_den;
	logic [16:0]        tk_full;
	logic [15:0]        tk;
	logic signed [52:0] yq_prod;
	logic [45:0]        u_prod;
	logic [60:0]        t_prod;
	logic signed [9:0]  shamt;
	logic [47:0]        m_sh;
	logic [13:0]        rh;
	logic [32:0]        pa;
	logic [37:0]        pva_raw;
	logic [32:0]        pva_c;
	logic [21:0]        eq_mag;
	logic [20:0]        rho_sum;

	vap_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign tc_ext  = {cfg.temp[14], cfg.temp};
	assign tc_mag  = cfg.temp[14] ? (~tc_ext + 16'd1) : tc_ext;
	assign tc_prod = 35'(K_TC_SCALE) * 35'(tc_mag);
	assign tc_den  = {{2{cfg.temp[14]}}, cfg.temp} + K_TC_OFFS;
	assign tk_full = {{2{cfg.temp[14]}}, cfg.temp} + K_TK_OFFS;
	assign tk      = tk_full[15:0];
	assign yq_prod = $signed(eq_q) * $signed({1'b0, K_LOG2_10});
	assign u_prod  = 46'(yq_q[15:0]) * 46'(K_LN2);
	assign t_prod  = 61'(term_q) * 61'(u_q);
	// 14 - n, n being the integer part of the exponent
	assign shamt   = 10'sd14 - {yq_q[24], yq_q[24:16]};
	always_comb begin
		if (shamt[9])
			m_sh = m_q;
		else if (|shamt[8:6])
			m_sh = '0;
		else
			m_sh = m_q >> shamt[5:0];
	end
	assign rh      = (cfg.humidity > K_RH_MAX) ? K_RH_MAX : cfg.humidity;
	assign pa      = {cfg.ambient, 16'd0};
	assign pva_raw = div_rsp.quot[37:0];
	assign pva_c   = (pva_raw > 38'(pa)) ? pa : pva_raw[32:0];
	assign eq_mag  = {1'b0, div_rsp.quot[20:0]};
	assign rho_sum = {1'b0, r1_q} + 21'(div_rsp.quot[RHO_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_EQ;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		div_req = '0;
		unique case (state_q)
			S_IDLE: ;
			S_EQ: begin
				div_req.go       = 1'b1;
				div_req.dividend = DIVN_W'(tc_prod);
				div_req.divisor  = DIVD_W'(tc_den);
				state_d          = S_EQ_W;
			end
			S_EQ_W: if (div_rsp.done) state_d = S_YQ;
			S_YQ:   state_d = S_U;
			S_U:    state_d = S_TERM;
			S_TERM: begin
				div_req.go       = 1'b1;
				div_req.dividend = DIVN_W'(t_prod[60:30]);
				div_req.divisor  = DIVD_W'(k_q);
				state_d          = S_TERM_W;
			end
			S_TERM_W: begin
				if (div_rsp.done)
					state_d = (k_q == EXP_TERMS) ? S_PVS : S_TERM;
			end
			S_PVS:   state_d = S_PVS_D;
			S_PVS_D: begin
				div_req.go       = 1'b1;
				div_req.dividend = DIVN_W'(m_sh);
				div_req.divisor  = DIVD_W'(K_HUNDRED);
				state_d          = S_PVS_W;
			end
			S_PVS_W: if (div_rsp.done) state_d = S_PVA;
			S_PVA: begin
				div_req.go       = 1'b1;
				div_req.dividend = 52'(pvs_q) * 52'(rh);
				div_req.divisor  = DIVD_W'(K_RH_MAX);
				state_d          = S_PVA_W;
			end
			S_PVA_W: if (div_rsp.done) state_d = S_R1;
			S_R1: begin
				div_req.go       = 1'b1;
				div_req.dividend = 52'(pd_q) * 52'(K_RHO_SCL);
				div_req.divisor  = 35'(K_RD) * 35'(tk);
				state_d          = S_R1_W;
			end
			S_R1_W: if (div_rsp.done) state_d = S_R2;
			S_R2: begin
				div_req.go       = 1'b1;
				div_req.dividend = 52'(pva_q) * 52'(K_RHO_SCL);
				div_req.divisor  = 35'(K_RV) * 35'(tk);
				state_d          = S_R2_W;
			end
			S_R2_W: if (div_rsp.done) state_d = S_SQ;
			S_SQ:   state_d = S_DEN;
			S_DEN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// any setting change restarts the whole sequence
		if (cfg_we)
			state_d = S_EQ;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_EQ_W: begin
				if (div_rsp.done) begin
					// floor division for a negative temperature
					if (cfg.temp[14])
						eq_q <= $signed((~eq_mag + 22'd1) - {21'd0, div_rsp.rem_nz});
					else
						eq_q <= $signed(eq_mag);
				end
			end
			S_YQ: yq_q <= yq_prod[52:28];
			S_U: begin
				u_q    <= u_prod[45:16];
				term_q <= K_ONE;
				sum_q  <= 32'(K_ONE);
				k_q    <= 4'd1;
			end
			S_TERM_W: begin
				if (div_rsp.done) begin
					term_q <= div_rsp.quot[30:0];
					sum_q  <= sum_q + 32'(div_rsp.quot[30:0]);
					k_q    <= k_q + 4'd1;
				end
			end
			S_PVS: m_q <= 48'(K_PVS) * 48'(sum_q);
			S_PVS_W: if (div_rsp.done) pvs_q <= div_rsp.quot[37:0];
			S_PVA_W: begin
				if (div_rsp.done) begin
					pva_q <= pva_c;
					pd_q  <= pa - pva_c;
				end
			end
			S_R1_W: if (div_rsp.done) r1_q <= div_rsp.quot[RHO_W-1:0];
			S_R2_W: begin
				if (div_rsp.done)
					rho_q <= (rho_sum == '0) ? RHO_W'(1) : rho_sum[RHO_W-1:0];
			end
			S_SQ: begin
				isq_q <= 32'(cfg.inlet) * 32'(cfg.inlet);
				tsq_q <= 32'(cfg.throat) * 32'(cfg.throat);
			end
			S_DEN: begin
				fc_q.den     <= DEN_W'(isq_q - tsq_q) * DEN_W'(rho_q);
				fc_q.coef    <= COEF_W'(K_SPEED) * COEF_W'(tsq_q);
				fc_q.geo_err <= cfg.inlet <= cfg.throat;
			end
			default: ;
		endcase
	end

	assign fc   = fc_q;
	assign busy = (state_q != S_IDLE);

endmodule

FILE: design/vap_div_cell.sv
// -----------------------------------------------------------------------------
// Division cell
// One restoring step of the speed-squared quotient.
// -----------------------------------------------------------------------------
module vap_div_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [vap_pkg::DEN_W-1:0]  den,
	input  vap_pkg::meta_t             meta_in,
	input  logic [vap_pkg::DEN_W-1:0]  rem_in,
	input  logic [vap_pkg::Q_W-1:0]    bits_in,
	output vap_pkg::meta_t             meta_out,
	output logic [vap_pkg::DEN_W-1:0]  rem_out,
	output logic [vap_pkg::Q_W-1:0]    bits_out
);
	import vap_pkg::*;

	logic [DEN_W:0] r;
	logic [DEN_W:0] r_sub;
	logic           ge;

	// remainder picks up the next numerator bit, quotient bit enters at the bottom
	assign r     = {rem_in, bits_in[Q_W-1]};
	assign ge    = r >= {1'b0, den};
	assign r_sub = r - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			meta_out <= '0;
		else
			meta_out <= meta_in;
	end

	always_ff @(posedge clk) begin
		rem_out  <= ge ? r_sub[DEN_W-1:0] : r[DEN_W-1:0];
		bits_out <= {bits_in[Q_W-2:0], ge};
	end

endmodule

FILE: design/vap_sqrt_cell.sv
// -----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit step of the integer square root.
// -----------------------------------------------------------------------------
module vap_sqrt_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vap_pkg::meta_t              meta_in,
	input  logic [vap_pkg::Q_W-1:0]     x_in,
	input  logic [vap_pkg::SREM_W-1:0]  rem_in,
	input  logic [vap_pkg::ROOT_W-1:0]  root_in,
	output vap_pkg::meta_t              meta_out,
	output logic [vap_pkg::Q_W-1:0]     x_out,
	output logic [vap_pkg::SREM_W-1:0]  rem_out,
	output logic [vap_pkg::ROOT_W-1:0]  root_out
);
	import vap_pkg::*;

	logic [SREM_W+1:0] r;
	logic [SREM_W+1:0] trial;
	logic [SREM_W+1:0] r_sub;
	logic              ge;

	assign r     = {rem_in, x_in[Q_W-1:Q_W-2]};
	assign trial = {(SREM_W+2-ROOT_W-2)'(0), root_in, 2'b01};
	assign ge    = r >= trial;
	assign r_sub = r - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			meta_out <= '0;
		else
			meta_out <= meta_in;
	end

	always_ff @(posedge clk) begin
		x_out    <= {x_in[Q_W-3:0], 2'b00};
		rem_out  <= ge ? r_sub[SREM_W-1:0] : r[SREM_W-1:0];
		root_out <= {root_in[ROOT_W-2:0], ge};
	end

endmodule

FILE: design/venturi_airspeed_from_pressure.sv
// -----------------------------------------------------------------------------
// Venturi airspeed from differential pressure
// Signed air speed in mm/s from one venturi pressure sample per transfer.
// -----------------------------------------------------------------------------
// Path to done: stages 1 and 2, both cell chains, the output register.
// Throughput: one sample per cycle while busy is low; fully pipelined.
// busy rises after reset and after every register write
// while the density sequencer runs its shared one-bit-per-cycle divider.
// Reset clears the settings to their defaults and empties the cell chain.
// Results cannot be held off: done marks each result for exactly one cycle.
module venturi_airspeed_from_pressure (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [vap_pkg::DP_W-1:0]        diff_pressure_centipa,
	output logic                                   done,
	output logic signed [vap_pkg::SPD_W-1:0]       speed_mm_per_s,
	output logic                                   geometry_error,
	output logic                                   saturated,
	input  logic                                   cfg_we,
	input  logic [vap_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vap_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
	import vap_pkg::*;

	// ---- settings -------------------------------------------------------
	cfg_t        cfg_q;
	flow_const_t fc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INLET:    cfg_q.inlet    <= cfg_wdata[15:0];
				REG_THROAT:   cfg_q.throat   <= cfg_wdata[15:0];
				REG_AMBIENT:  cfg_q.ambient  <= cfg_wdata[16:0];
				REG_HUMIDITY: cfg_q.humidity <= cfg_wdata[13:0];
				REG_TEMP:     cfg_q.temp     <= $signed(cfg_wdata[14:0]);
				default: ;
			endcase
		end
	end

	// Density and the two flow constants are rebuilt after any write; they
	// hold steady while samples stream, so the chain just reads them.
	vap_density u_density (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cfg_we (cfg_we),
		.fc     (fc),
		.busy   (busy)
	);

	// ---- stage 1: magnitude times coefficient, split in two halves ------
	logic                 accept;
	logic [DP_W-1:0]      dp_mag;
	meta_t                meta_s1;
	logic [55:0]          p_lo_s1;
	logic [54:0]          p_hi_s1;

	assign accept = start && !busy;
	assign dp_mag = diff_pressure_centipa[DP_W-1] ?
		(~diff_pressure_centipa + DP_W'(1)) : diff_pressure_centipa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			meta_s1 <= '0;
		else
			meta_s1 <= '{vld: accept, neg: diff_pressure_centipa[DP_W-1],
				zero: (diff_pressure_centipa == '0), geo: fc.geo_err, sat: 1'b0};
	end

	always_ff @(posedge clk) begin
		p_lo_s1 <= 56'(dp_mag) * 56'(fc.coef[31:0]);
		p_hi_s1 <= 55'(dp_mag) * 55'(fc.coef[COEF_W-1:32]);
	end

	// ---- stage 2: numerator, overflow check, split for the divider -----
	logic [NUM_W-1:0] num_c;
	logic             sat_c;
	meta_t            meta_s2;
	logic [DEN_W-1:0] rem_s2;
	logic [Q_W-1:0]   bits_s2;

	assign num_c = {p_hi_s1, 32'd0} + NUM_W'(p_lo_s1);
	// q would need more than 34 bits: speed is pinned at full scale
	assign sat_c = num_c >= NUM_W'({fc.den, Q_W'(0)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else begin
			meta_s2 <= '{vld: meta_s1.vld, neg: meta_s1.neg, zero: meta_s1.zero,
				geo: meta_s1.geo, sat: sat_c};
		end
	end

	// below the overflow bound the top part is already under den
	always_ff @(posedge clk) begin
		rem_s2  <= num_c[NUM_W-2:Q_W];
		bits_s2 <= num_c[Q_W-1:0];
	end

	// ---- division chain: one quotient bit per cell ----------------------
	meta_t            dv_meta [0:DIV_CELLS];
	logic [DEN_W-1:0] dv_rem  [0:DIV_CELLS];
	logic [Q_W-1:0]   dv_bits [0:DIV_CELLS];

	assign dv_meta[0] = meta_s2;
	assign dv_rem[0]  = rem_s2;
	assign dv_bits[0] = bits_s2;

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		vap_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.den      (fc.den),
			.meta_in  (dv_meta[i]),
			.rem_in   (dv_rem[i]),
			.bits_in  (dv_bits[i]),
			.meta_out (dv_meta[i+1]),
			.rem_out  (dv_rem[i+1]),
			.bits_out (dv_bits[i+1])
		);
	end

	// ---- square-root chain: one root bit per cell ------------------------
	meta_t             sq_meta [0:SQRT_CELLS];
	logic [Q_W-1:0]    sq_x    [0:SQRT_CELLS];
	logic [SREM_W-1:0] sq_rem  [0:SQRT_CELLS];
	logic [ROOT_W-1:0] sq_root [0:SQRT_CELLS];

	assign sq_meta[0] = dv_meta[DIV_CELLS];
	assign sq_x[0]    = dv_bits[DIV_CELLS];
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
		vap_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.meta_in  (sq_meta[j]),
			.x_in     (sq_x[j]),
			.rem_in   (sq_rem[j]),
			.root_in  (sq_root[j]),
			.meta_out (sq_meta[j+1]),
			.x_out    (sq_x[j+1]),
			.rem_out  (sq_rem[j+1]),
			.root_out (sq_root[j+1])
		);
	end

	// ---- output register ------------------------------------------------
	meta_t             fin;
	logic [ROOT_W-1:0] mag_c;
	logic [SPD_W-1:0]  mag_ext;
	logic [SPD_W-1:0]  speed_c;
	logic              done_q;
	logic [SPD_W-1:0]  speed_q;
	logic              geo_q;
	logic              sat_q;

	assign fin     = sq_meta[SQRT_CELLS];
	assign mag_c   = fin.sat ? SPEED_MAX : sq_root[SQRT_CELLS];
	assign mag_ext = {1'b0, mag_c};
	// suction (negative dp) is forward flow
	always_comb begin
		if (fin.geo || fin.zero)
			speed_c = '0;
		else if (fin.neg)
			speed_c = mag_ext;
		else
			speed_c = ~mag_ext + SPD_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= fin.vld;
	end

	always_ff @(posedge clk) begin
		speed_q <= speed_c;
		geo_q   <= fin.geo;
		sat_q   <= fin.sat && !fin.geo && !fin.zero;
	end

	assign done           = done_q;
	assign speed_mm_per_s = $signed(speed_q);
	assign geometry_error = geo_q;
	assign saturated      = sat_q;

endmodule

FILE: design/vap_checker.sv
// -----------------------------------------------------------------------------
// Venturi airspeed port checker
// Watches the top-level ports for timing and result consistency.
// -----------------------------------------------------------------------------
`include "venturi_airspeed_from_pressure_assert.svh"

module vap_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   done,
	input logic signed [vap_pkg::SPD_W-1:0]       speed_mm_per_s,
	input logic                                   geometry_error,
	input logic                                   saturated,
	input logic                                   cfg_we
);
	import vap_pkg::*;

	localparam logic signed [SPD_W-1:0] SPD_POS = 18'sd131071;
	localparam logic signed [SPD_W-1:0] SPD_NEG = -18'sd131071;

	`VAP_ASSERT_DLY(a_latency, clk, arst_n, start && !busy, LATENCY, done, "result missing after a transfer")
	`VAP_ASSERT_NXT(a_cfg_busy, clk, arst_n, cfg_we, busy, "no recompute after a register write")
	`VAP_ASSERT_IMP(a_geo_zero, clk, arst_n, done && geometry_error, speed_mm_per_s == '0 && !saturated, "bad geometry result not zero")
	`VAP_ASSERT_IMP(a_sat_full, clk, arst_n, done && saturated, speed_mm_per_s == SPD_POS || speed_mm_per_s == SPD_NEG, "saturated speed not at full scale")

endmodule

bind venturi_airspeed_from_pressure vap_checker u_vap_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.speed_mm_per_s (speed_mm_per_s),
	.geometry_error (geometry_error),
	.saturated      (saturated),
	.cfg_we         (cfg_we)
);

FILE: dv/tb_venturi_airspeed_from_pressure.sv
// -----------------------------------------------------------------------------
// Venturi airspeed testbench
// Sends pressure samples under a range of geometry and air settings, predicts
// every speed and both flags in a scoreboard and checks them as they arrive.
// -----------------------------------------------------------------------------
module tb_venturi_airspeed_from_pressure;

	import vap_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 93;

	// expected outcome of one sample
	typedef struct {
		logic signed [SPD_W-1:0] speed;
		logic                    geo;
		logic                    sat;
	} speed_result_t;

	// -------------------------------------------------------------------------
	// scoreboard: own copy of the settings, density and speed maths
	// -------------------------------------------------------------------------
	class speed_scoreboard;
		cfg_t          regs;
		speed_result_t pending_speeds[$];
		int            n_sat;
		int            n_geo;

		function new();
			regs = CFG_RESET;
		endfunction

		static function longint floor_div(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && ((a < 0) != (b < 0)))
				q = q - 1;
			return q;
		endfunction

		// air density, Q4.16 kg/m^3
		function logic [63:0] air_density();
			longint      tc, eq, yq, n, s;
			logic [63:0] f, u, term, sum, m, pvs, pva, pa, pd, tk, h, rho;
			tc = longint'(regs.temp);
			eq = floor_div(491520 * tc, tc + 23730);
			yq = floor_div(eq * 891723283, longint'(1) << 28);
			n  = floor_div(yq, 65536);
			f  = 64'(yq - n * 65536);
			u  = (f * 64'd744261118) >> 16;
			term = 64'd1 << 30;
			sum  = term;
			for (int k = 1; k <= 8; k++) begin
				term = ((term * u) >> 30) / 64'(k);
				sum  = sum + term;
			end
			m = 64'd61078 * sum;
			s = 14 - n;
			if (s < 0)
				s = 0;
			pvs = (s >= 64) ? 64'd0 : ((m >> s) / 64'd100);
			h   = (regs.humidity > 14'd10000) ? 64'd10000 : 64'(regs.humidity);
			pva = pvs * h / 64'd10000;
			pa  = 64'(regs.ambient) << 16;
			if (pva > pa)
				pva = pa;
			pd  = pa - pva;
			tk  = 64'(tc + 27313);
			rho = pd * 64'd100000 / (64'd287058 * tk) + pva * 64'd100000 / (64'd461495 * tk);
			return (rho == 0) ? 64'd1 : rho;
		endfunction

		function speed_result_t predict_speed(logic signed [DP_W-1:0] dp);
			speed_result_t r;
			logic [63:0]   mag, in2, th2, den;
			logic [127:0]  num, q, root, t;
			r.speed = '0;
			r.geo   = 1'b0;
			r.sat   = 1'b0;
			if (regs.inlet <= regs.throat) begin
				r.geo = 1'b1;
				return r;
			end
			if (dp == 0)
				return r;
			mag = (dp < 0) ? 64'(-longint'(dp)) : 64'(longint'(dp));
			in2 = 64'(regs.inlet) * 64'(regs.inlet);
			th2 = 64'(regs.throat) * 64'(regs.throat);
			den = (in2 - th2) * air_density();
			num = 128'(64'd1310720000 * mag) * 128'(th2);
			if (num >= (128'(den) << 34)) begin
				root  = 128'(SPEED_MAX);
				r.sat = 1'b1;
			end else begin
				q    = num / 128'(den);
				root = '0;
				for (int b = 17; b >= 0; b--) begin
					t = root + (128'd1 << b);
					if (t * t <= q)
						root = t;
				end
			end
			r.speed = (dp < 0) ? SPD_W'(root) : SPD_W'(-root);
			return r;
		endfunction

		function void note_sample(logic signed [DP_W-1:0] dp);
			speed_result_t r;
			r = predict_speed(dp);
			n_sat += r.sat;
			n_geo += r.geo;
			pending_speeds.push_back(r);
		endfunction

		// empty string when the result matches
		function string check_speed(logic signed [SPD_W-1:0] spd, logic geo, logic sat);
			speed_result_t e;
			string         msg;
			if (pending_speeds.size() == 0)
				return $sformatf("unexpected result speed=%0d", spd);
			e   = pending_speeds.pop_front();
			msg = "";
			if (spd !== e.speed)
				msg = {msg, $sformatf(" speed %0d/%0d", spd, e.speed)};
			if (geo !== e.geo)
				msg = {msg, $sformatf(" geometry_error %0b/%0b", geo, e.geo)};
			if (sat !== e.sat)
				msg = {msg, $sformatf(" saturated %0b/%0b", sat, e.sat)};
			return (msg == "") ? "" : {"got/exp", msg};
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [DP_W-1:0]  diff_pressure_centipa;
	logic                    done;
	logic signed [SPD_W-1:0] speed_mm_per_s;
	logic                    geometry_error;
	logic                    saturated;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;

	speed_scoreboard sb = new();
	int              n_errors;
	int              n_sent;
	int              n_checked;
	int              cycles;
	bit              gaps_on;

	venturi_airspeed_from_pressure uut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.start                 (start),
		.busy                  (busy),
		.diff_pressure_centipa (diff_pressure_centipa),
		.done                  (done),
		.speed_mm_per_s        (speed_mm_per_s),
		.geometry_error        (geometry_error),
		.saturated             (saturated),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_wdata             (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.pending_speeds.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report(string msg);
		$display("[%0d] mismatch: %s", cycles, msg);
		n_errors++;
	endtask

	// result side: done strobes one cycle, nothing to hold off
	always @(posedge clk) begin
		string msg;
		if (arst_n && done) begin
			msg = sb.check_speed(speed_mm_per_s, geometry_error, saturated);
			n_checked++;
			if (msg != "")
				report(msg);
		end
	end

	// random idle: mostly none or short, now and then long
	task automatic idle_gap();
		int g;
		int sel;
		sel = $urandom_range(0, 99);
		if (!gaps_on || sel < 55)
			g = 0;
		else if (sel < 92)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(15, 70);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// one sample transfer; start stays up across back-to-back items
	task automatic send_sample(logic signed [DP_W-1:0] dp);
		start                 <= 1'b1;
		diff_pressure_centipa <= dp;
		do
			@(posedge clk);
		while (busy);
		sb.note_sample(dp);
		n_sent++;
		idle_gap();
	endtask

	// block idle: results all in, then an idle margin
	task automatic drain();
		start <= 1'b0;
		while (sb.pending_speeds.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_INLET:    sb.regs.inlet    = value[15:0];
			REG_THROAT:   sb.regs.throat   = value[15:0];
			REG_AMBIENT:  sb.regs.ambient  = value[16:0];
			REG_HUMIDITY: sb.regs.humidity = value[13:0];
			REG_TEMP:     sb.regs.temp     = value[14:0];
			default: ;
		endcase
		// density recompute
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic set_air(logic [15:0] inl, logic [15:0] thr, logic [16:0] amb,
			logic [13:0] hum, logic signed [14:0] tc);
		drain();
		cfg_write(REG_INLET, 17'(inl));
		cfg_write(REG_THROAT, 17'(thr));
		cfg_write(REG_AMBIENT, amb);
		cfg_write(REG_HUMIDITY, 17'(hum));
		// upper data bits lie outside the register and must be ignored
		cfg_write(REG_TEMP, {2'($urandom_range(0, 3)), tc});
	endtask

	function automatic logic signed [DP_W-1:0] rand_sample();
		logic [DP_W-1:0] mag;
		int              sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel < 6)
			return DP_W'($urandom);
		// spread magnitudes over all octaves
		mag = DP_W'($urandom >> $urandom_range(8, 31));
		return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
	endfunction

	initial begin
		logic [15:0]        thr, inl;
		logic [16:0]        amb;
		logic [13:0]        hum;
		logic signed [14:0] tc;
		logic signed [DP_W-1:0] directed[] = '{
			24'sd0, 24'sd1, -24'sd1, 24'sd8388607, -24'sd8388608, 24'sd100, -24'sd100,
			24'sd2000000, -24'sd3000000, 24'sd3100000, -24'sd3100000, 24'sd5592405,
			-24'sd2796202, 24'sd12345, -24'sd65536
		};

		arst_n                = 1'b0;
		start                 = 1'b0;
		diff_pressure_centipa = '0;
		cfg_we                = 1'b0;
		cfg_index             = REG_INLET;
		cfg_wdata             = '0;
		cycles                = 0;
		n_errors              = 0;
		n_sent                = 0;
		n_checked             = 0;
		gaps_on               = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: sign, zero, extremes and the saturation boundary
		foreach (directed[i])
			send_sample(directed[i]);

		// geometry: equal sizes and inlet smaller are faults; a zero throat is not
		set_air(16'd1000, 16'd1000, 17'd101325, 14'd5000, 15'sd2000);
		send_sample(24'sd5000);
		set_air(16'd65535, 16'd0, 17'd101325, 14'd5000, 15'sd2000);
		send_sample(-24'sd5000);
		set_air(16'd1, 16'd65535, 17'd101325, 14'd5000, 15'sd2000);
		send_sample(24'sd0);
		send_sample(-24'sd8388608);

		// zero density (no air at all), widest ratio
		set_air(16'd65535, 16'd1, 17'd0, 14'd0, 15'sd0);
		send_sample(24'sd8388607);
		send_sample(-24'sd1);

		// hot and saturated: vapour over ambient, humidity over full scale
		set_air(16'd2, 16'd1, 17'd30000, 14'd16383, 15'sd16383);
		send_sample(24'sd1);
		send_sample(-24'sd8388607);

		// cold limits and top of pressure field
		set_air(16'd65535, 16'd65534, 17'd131071, 14'd10000, -15'sd16384);
		send_sample(24'sd8388607);
		send_sample(-24'sd4000);
		set_air(16'd3000, 16'd1000, 17'd110000, 14'd0, -15'sd4000);
		send_sample(-24'sd777777);

		// random phases
		for (int p = 0; p < N_PHASES; p++) begin
			thr = 16'($urandom_range(1, 4000));
			inl = (p % 4 == 3) ? 16'($urandom_range(0, thr))
				: 16'(thr + $urandom_range(1, 4 * thr));
			if (p % 5 == 1) begin
				thr = 16'($urandom_range(1, 65534));
				inl = 16'($urandom_range(thr + 1, 65535));
			end
			amb = (p % 6 == 2) ? 17'($urandom) : 17'($urandom_range(30000, 110000));
			hum = (p % 4 == 1) ? 14'($urandom) : 14'($urandom_range(0, 10000));
			tc  = (p % 5 == 4) ? 15'($urandom) : 15'($urandom_range(0, 12500) - 4000);
			set_air(inl, thr, amb, hum, tc);
			gaps_on = (p % 3 != 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_sample(rand_sample());
				// sender holds back until the pipe has emptied
				if (p == 2 && i == PHASE_ITEMS / 2) begin
					start <= 1'b0;
					while (sb.pending_speeds.size() != 0)
						@(posedge clk);
				end
			end
		end

		drain();
		$display("%0d samples sent over %0d settings, %0d results checked",
			n_sent, N_PHASES + 8, n_checked);
		$display("%0d saturated, %0d with bad geometry", sb.n_sat, sb.n_geo);
		if (n_errors == 0 && sb.pending_speeds.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
